@@ rtl/load_cell_adc_serial_reader_top_macros.svh @@
// Assertion macros shared by the load-cell reader RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef LOAD_CELL_ADC_SERIAL_READER_TOP_MACROS_SVH
`define LOAD_CELL_ADC_SERIAL_READER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define LCASR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define LCASR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define LCASR_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define LCASR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/lcasr_pkg.sv @@
// Package for the load-cell reader: payload structs, codes and constants.
// Depends on nothing; used by lcasr_core and the top level.
package lcasr_pkg;

    localparam int DATA_BITS = 24;
    localparam logic [23:0] OFFSET_FLIP = 24'h800000;
    localparam logic [23:0] WAIT_MAX = 24'hFFFFFF;

    localparam logic [23:0] TIMEOUT_RESET = 24'd1000000;
    localparam logic [7:0] HALF_RESET = 8'd1;
    localparam logic [1:0] EXTRA_RESET = 2'd1;

    // Configuration register indexes.
    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_HALF = 2'd1;
    localparam logic [1:0] REG_EXTRA = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_PDOWN = 2'd2,
        CMD_PUP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_WAIT = 3'd1,
        PH_HIGH = 3'd2,
        PH_LOW  = 3'd3,
        PH_DOWN = 3'd4
    } phase_t;

    typedef struct packed {
        logic [1:0] command;
        logic       dout_level;
    } in_t;

    typedef struct packed {
        logic        sck_level;
        logic        busy_res;
        logic        done_res;
        logic        ok;
        logic [23:0] sample;
    } out_t;

    typedef struct packed {
        logic [23:0] timeout_ticks;
        logic [7:0]  half_period_ticks;
        logic [1:0]  extra_pulses;
    } cfg_t;

endpackage

@@ rtl/lcasr_core.sv @@
// Tick sequencer of the load-cell reader: state registers and per-tick logic.
// Depends on lcasr_pkg and the assertion macro header.
`include "load_cell_adc_serial_reader_top_macros.svh"

module lcasr_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  lcasr_pkg::in_t    item,
    input  lcasr_pkg::cfg_t   cfg,
    output lcasr_pkg::out_t   result
);

    lcasr_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  pulse_count_reg, pulse_count_next;
    logic [23:0] shift_word_reg, shift_word_next;
    logic [23:0] wait_timer_reg, wait_timer_next;
    logic [7:0]  half_timer_reg, half_timer_next;
    logic        clock_out_reg, clock_out_next;

    logic [23:0] timeout_eff;
    logic [7:0]  half_eff;
    logic [4:0]  total_pulses;
    logic        in_idle, in_wait, in_low, in_down;
    logic        is_down, is_start, is_pup;
    logic [8:0]  half_sum;
    logic        half_hit;
    logic [23:0] wait_inc;
    logic        wait_hit;
    logic [4:0]  pulse_inc;
    logic        last_pulse;
    logic        done, ok;

    // Zero-valued registers behave as one.
    assign timeout_eff = (cfg.timeout_ticks == '0) ? 24'd1 : cfg.timeout_ticks;
    assign half_eff = (cfg.half_period_ticks == '0) ? 8'd1 : cfg.half_period_ticks;
    assign total_pulses = 5'(lcasr_pkg::DATA_BITS)
        + ((cfg.extra_pulses == '0) ? 5'd1 : {3'b000, cfg.extra_pulses});

    // Phase decode.
    assign in_idle = (phase_reg == lcasr_pkg::PH_IDLE);
    assign in_wait = (phase_reg == lcasr_pkg::PH_WAIT);
    assign in_low = (phase_reg == lcasr_pkg::PH_LOW);
    assign in_down = (phase_reg == lcasr_pkg::PH_DOWN);

    // Command decode and timer comparisons.
    assign is_down = (item.command == lcasr_pkg::CMD_PDOWN);
    assign is_start = (item.command == lcasr_pkg::CMD_START) && (in_idle || in_down);
    assign is_pup = (item.command == lcasr_pkg::CMD_PUP) && in_down;
    assign half_sum = {1'b0, half_timer_reg} + 9'd1;
    assign half_hit = (half_sum >= {1'b0, half_eff});
    assign wait_inc = (wait_timer_reg < lcasr_pkg::WAIT_MAX) ? wait_timer_reg + 24'd1
                                                             : wait_timer_reg;
    assign wait_hit = (wait_inc >= timeout_eff);
    assign pulse_inc = pulse_count_reg + 5'd1;
    assign last_pulse = (pulse_inc >= total_pulses);

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        priority if (is_down) begin
            phase_next = lcasr_pkg::PH_DOWN;
        end else if (is_start) begin
            phase_next = lcasr_pkg::PH_WAIT;
        end else if (is_pup) begin
            phase_next = lcasr_pkg::PH_IDLE;
        end else if (in_wait) begin
            if (!item.dout_level) begin
                phase_next = lcasr_pkg::PH_HIGH;
            end else if (wait_hit) begin
                phase_next = lcasr_pkg::PH_IDLE;
            end
        end else if (phase_reg == lcasr_pkg::PH_HIGH) begin
            if (half_hit) begin
                phase_next = lcasr_pkg::PH_LOW;
            end
        end else if (in_low) begin
            if (half_hit) begin
                phase_next = last_pulse ? lcasr_pkg::PH_IDLE : lcasr_pkg::PH_HIGH;
            end
        end else begin
            phase_next = phase_reg;
        end
    end

    // Datapath registers and the done/ok flags.
    always_comb begin
        pulse_count_next = pulse_count_reg;
        shift_word_next = shift_word_reg;
        wait_timer_next = wait_timer_reg;
        half_timer_next = half_timer_reg;
        clock_out_next = clock_out_reg;
        done = 1'b0;
        ok = 1'b0;
        priority if (is_down) begin
            clock_out_next = 1'b1;
            half_timer_next = '0;
            wait_timer_next = '0;
            pulse_count_next = '0;
        end else if (is_start) begin
            clock_out_next = 1'b0;
            wait_timer_next = '0;
        end else if (is_pup) begin
            clock_out_next = 1'b0;
        end else if (in_wait) begin
            if (!item.dout_level) begin
                clock_out_next = 1'b1;
                half_timer_next = '0;
                pulse_count_next = '0;
                shift_word_next = '0;
            end else begin
                wait_timer_next = wait_inc;
                done = wait_hit;
            end
        end else if (phase_reg == lcasr_pkg::PH_HIGH) begin
            half_timer_next = half_sum[7:0];
            if (half_hit) begin
                half_timer_next = '0;
                clock_out_next = 1'b0;
            end
        end else if (in_low) begin
            half_timer_next = half_sum[7:0];
            if (half_hit) begin
                half_timer_next = '0;
                if (pulse_count_reg < 5'(lcasr_pkg::DATA_BITS)) begin
                    shift_word_next = {shift_word_reg[22:0], item.dout_level};
                end
                pulse_count_next = pulse_inc;
                clock_out_next = !last_pulse;
                done = last_pulse;
                ok = last_pulse;
            end
        end else begin
            clock_out_next = clock_out_reg;
        end
    end

    // Result of this tick.
    always_comb begin
        result.sck_level = clock_out_next;
        result.busy_res = (phase_next == lcasr_pkg::PH_WAIT)
            || (phase_next == lcasr_pkg::PH_HIGH) || (phase_next == lcasr_pkg::PH_LOW);
        result.done_res = done;
        result.ok = ok;
        result.sample = ok ? (shift_word_next ^ lcasr_pkg::OFFSET_FLIP) : '0;
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= lcasr_pkg::PH_IDLE;
            pulse_count_reg <= '0;
            shift_word_reg <= '0;
            wait_timer_reg <= '0;
            half_timer_reg <= '0;
            clock_out_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            pulse_count_reg <= pulse_count_next;
            shift_word_reg <= shift_word_next;
            wait_timer_reg <= wait_timer_next;
            half_timer_reg <= half_timer_next;
            clock_out_reg <= clock_out_next;
        end
    end

    // Power-down always drives the clock line high.
    `LCASR_ASSERT_NOW(a_down_clock_high, aclk, aresetn, in_down, clock_out_reg)
    // The clock line is low whenever idle or waiting for data ready.
    `LCASR_ASSERT_NOW(a_idle_clock_low, aclk, aresetn, in_idle || in_wait, !clock_out_reg)
    // A finished read leaves the sequencer idle on the next cycle.
    `LCASR_ASSERT_NEXT(a_done_to_idle, aclk, aresetn, step_en && done, in_idle)
    // A successful result only comes out of the low half of a pulse.
    `LCASR_ASSERT_NOW(a_ok_from_low, aclk, aresetn, step_en && ok, in_low && done)

endmodule

@@ rtl/load_cell_adc_serial_reader_top.sv @@
// A transaction accepted into the input register passes through the sequencer step
// into the output register. One tick transaction per cycle while the result side
// accepts, set by the single-pass sequencer step; an output stall holds the input.
// Reset (aresetn low, synchronous) empties both registers, idles the sequencer
// with the clock line low, and loads the configuration reset values.
// Depends on lcasr_pkg and lcasr_core.
module load_cell_adc_serial_reader_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lcasr_pkg::in_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lcasr_pkg::out_t   m_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_addr,
    input  logic [23:0]       cfg_wdata
);

    logic            in_valid_reg;
    lcasr_pkg::in_t  in_data_reg;
    logic            out_valid_reg;
    lcasr_pkg::out_t out_data_reg;
    lcasr_pkg::cfg_t cfg_reg;
    lcasr_pkg::out_t step_result;
    logic            advance;

    // A held transaction moves to the output register when that register frees.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data = out_data_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks <= lcasr_pkg::TIMEOUT_RESET;
            cfg_reg.half_period_ticks <= lcasr_pkg::HALF_RESET;
            cfg_reg.extra_pulses <= lcasr_pkg::EXTRA_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                lcasr_pkg::REG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_wdata;
                lcasr_pkg::REG_HALF:    cfg_reg.half_period_ticks <= cfg_wdata[7:0];
                lcasr_pkg::REG_EXTRA:   cfg_reg.extra_pulses <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    lcasr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

endmodule

@@ tb/load_cell_adc_serial_reader_checker.sv @@
// Checker for the load-cell reader: watches both channels and the register port.
// Predicts each result transaction from its own copy of the sequencer and compares.
// Depends on lcasr_pkg.
`timescale 1ns / 1ps

module load_cell_adc_serial_reader_checker (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_ready,
    input  lcasr_pkg::in_t  s_data,
    input  logic            m_valid,
    input  logic            m_ready,
    input  lcasr_pkg::out_t m_data,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_addr,
    input  logic [23:0]     cfg_wdata,
    output int              fail_count,
    output int              pending_count
);

    localparam int REPORT_LIMIT = 100;

    // Shadow registers and sequencer state.
    lcasr_pkg::cfg_t   regs;
    lcasr_pkg::phase_t seq_phase;
    logic [4:0]  pulse_count;
    logic [23:0] shift_word;
    logic [23:0] wait_timer;
    logic [7:0]  half_timer;
    logic        clk_level;

    lcasr_pkg::out_t expected_ticks[$];
    int   errors;

    // Advances the sequencer by one tick and returns the output it should show.
    function lcasr_pkg::out_t advance_sequencer(input lcasr_pkg::in_t item);
        logic [7:0]  half_eff;
        logic [4:0]  pulse_total;
        logic [23:0] limit_eff;
        lcasr_pkg::out_t res;
        half_eff = (regs.half_period_ticks == 8'd0) ? 8'd1 : regs.half_period_ticks;
        pulse_total = 5'(lcasr_pkg::DATA_BITS) + ((regs.extra_pulses == 2'd0) ? 5'd1
                                                  : 5'(regs.extra_pulses));
        limit_eff = (regs.timeout_ticks == 24'd0) ? 24'd1 : regs.timeout_ticks;
        res = '0;
        if (item.command == lcasr_pkg::CMD_PDOWN) begin
            seq_phase = lcasr_pkg::PH_DOWN;
            clk_level = 1'b1;
            half_timer = '0;
            wait_timer = '0;
            pulse_count = '0;
        end else if (item.command == lcasr_pkg::CMD_START
                     && (seq_phase == lcasr_pkg::PH_IDLE
                         || seq_phase == lcasr_pkg::PH_DOWN)) begin
            seq_phase = lcasr_pkg::PH_WAIT;
            clk_level = 1'b0;
            wait_timer = '0;
        end else if (item.command == lcasr_pkg::CMD_PUP
                     && seq_phase == lcasr_pkg::PH_DOWN) begin
            seq_phase = lcasr_pkg::PH_IDLE;
            clk_level = 1'b0;
        end else if (seq_phase == lcasr_pkg::PH_WAIT) begin
            // Data low means the converter is ready: the first pulse starts now.
            if (!item.dout_level) begin
                seq_phase = lcasr_pkg::PH_HIGH;
                clk_level = 1'b1;
                half_timer = '0;
                pulse_count = '0;
                shift_word = '0;
            end else begin
                if (wait_timer != lcasr_pkg::WAIT_MAX) begin
                    wait_timer = wait_timer + 24'd1;
                end
                if (wait_timer >= limit_eff) begin
                    seq_phase = lcasr_pkg::PH_IDLE;
                    res.done_res = 1'b1;
                end
            end
        end else if (seq_phase == lcasr_pkg::PH_HIGH) begin
            half_timer = half_timer + 8'd1;
            if (half_timer >= half_eff) begin
                half_timer = '0;
                clk_level = 1'b0;
                seq_phase = lcasr_pkg::PH_LOW;
            end
        end else if (seq_phase == lcasr_pkg::PH_LOW) begin
            // The data line is sampled at the end of the low half of each data pulse, not extra ones.
            half_timer = half_timer + 8'd1;
            if (half_timer >= half_eff) begin
                half_timer = '0;
                if (pulse_count < 5'(lcasr_pkg::DATA_BITS)) begin
                    shift_word = {shift_word[22:0], item.dout_level};
                end
                pulse_count = pulse_count + 5'd1;
                if (pulse_count >= pulse_total) begin
                    seq_phase = lcasr_pkg::PH_IDLE;
                    clk_level = 1'b0;
                    res.done_res = 1'b1;
                    res.ok = 1'b1;
                    res.sample = shift_word ^ lcasr_pkg::OFFSET_FLIP;
                end else begin
                    clk_level = 1'b1;
                    seq_phase = lcasr_pkg::PH_HIGH;
                end
            end
        end
        res.sck_level = clk_level;
        res.busy_res = (seq_phase == lcasr_pkg::PH_WAIT || seq_phase == lcasr_pkg::PH_HIGH
                        || seq_phase == lcasr_pkg::PH_LOW);
        return res;
    endfunction

    function void check_field(input string name, input logic [23:0] want,
                              input logic [23:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            end
        end
    endfunction

    // Track register writes, predict on input transactions, compare on results.
    always @(posedge aclk) begin : track
        lcasr_pkg::out_t oldest;
        if (!aresetn) begin
            regs.timeout_ticks = lcasr_pkg::TIMEOUT_RESET;
            regs.half_period_ticks = lcasr_pkg::HALF_RESET;
            regs.extra_pulses = lcasr_pkg::EXTRA_RESET;
            seq_phase = lcasr_pkg::PH_IDLE;
            pulse_count = '0;
            shift_word = '0;
            wait_timer = '0;
            half_timer = '0;
            clk_level = 1'b0;
            expected_ticks.delete();
            errors = 0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    lcasr_pkg::REG_TIMEOUT: regs.timeout_ticks = cfg_wdata;
                    lcasr_pkg::REG_HALF: regs.half_period_ticks = cfg_wdata[7:0];
                    lcasr_pkg::REG_EXTRA: regs.extra_pulses = cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_ticks.push_back(advance_sequencer(s_data));
            end
            if (m_valid && m_ready) begin
                if (expected_ticks.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT) begin
                        $error("result transaction with no prediction waiting");
                    end
                end else begin
                    oldest = expected_ticks.pop_front();
                    check_field("sck_level", 24'(oldest.sck_level), 24'(m_data.sck_level));
                    check_field("busy_res", 24'(oldest.busy_res), 24'(m_data.busy_res));
                    check_field("done_res", 24'(oldest.done_res), 24'(m_data.done_res));
                    check_field("ok", 24'(oldest.ok), 24'(m_data.ok));
                    check_field("sample", oldest.sample, m_data.sample);
                end
            end
        end
        fail_count <= errors;
        pending_count <= expected_ticks.size();
    end

endmodule

@@ tb/load_cell_adc_serial_reader_top_test.sv @@
// Testbench top for the load-cell reader: clock, reset, stimulus and verdict.
// Depends on lcasr_pkg, load_cell_adc_serial_reader_top and the checker module.
`timescale 1ns / 1ps

module load_cell_adc_serial_reader_top_test;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_BUDGET = 150;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    lcasr_pkg::in_t  s_data;
    logic        m_valid;
    logic        m_ready;
    lcasr_pkg::out_t m_data;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [23:0] cfg_wdata;
    int          fail_count;
    int          pending_count;

    // Stimulus bookkeeping.
    lcasr_pkg::cfg_t cur_cfg;
    bit   calm;
    int   items_sent;
    int   quiet_cycles;

    load_cell_adc_serial_reader_top uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    load_cell_adc_serial_reader_checker result_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .fail_count(fail_count),
        .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 50);
    endfunction

    function automatic int pick_gap();
        if (calm || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return pick_len();
    endfunction

    // Filler command inside a read: start and power-up act as plain ticks there.
    function automatic lcasr_pkg::cmd_t pick_filler(input bit noisy);
        if (noisy && $urandom_range(0, 7) == 0) begin
            return ($urandom_range(0, 1) == 1) ? lcasr_pkg::CMD_START : lcasr_pkg::CMD_PUP;
        end
        return lcasr_pkg::CMD_TICK;
    endfunction

    // Result side stalls at random.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) begin
                    stall_left = pick_len();
                end
            end
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[load_cell_adc_serial_reader_top] ERROR");
                $finish;
            end
        end
    end

    // Sends one tick transaction, after an optional gap.
    task automatic send_tick(input lcasr_pkg::cmd_t c, input logic d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{command: c, dout_level: d};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Holds the sender until every predicted result has come, then lets the block settle.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_settings(input lcasr_pkg::cfg_t c);
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= lcasr_pkg::REG_TIMEOUT;
        cfg_wdata <= c.timeout_ticks;
        @(posedge aclk);
        cfg_addr <= lcasr_pkg::REG_HALF;
        cfg_wdata <= {16'd0, c.half_period_ticks};
        @(posedge aclk);
        cfg_addr <= lcasr_pkg::REG_EXTRA;
        cfg_wdata <= {22'd0, c.extra_pulses};
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_cfg = c;
    endtask

    // One read: start, ready_delay busy checks, then the pulses carrying word.
    // A delay at or past the timeout gives a timed-out read instead.
    task automatic run_read(input int ready_delay, input logic [23:0] word, input bit noisy);
        bit levels[$];
        int half_n;
        int total;
        int tmo_eff;
        int abort_at;
        half_n = (cur_cfg.half_period_ticks == 8'd0) ? 1 : int'(cur_cfg.half_period_ticks);
        total = lcasr_pkg::DATA_BITS
                + ((cur_cfg.extra_pulses == 2'd0) ? 1 : int'(cur_cfg.extra_pulses));
        tmo_eff = (cur_cfg.timeout_ticks == 24'd0) ? 1 : int'(cur_cfg.timeout_ticks);
        calm = ($urandom_range(0, 4) == 0);
        if (ready_delay >= tmo_eff) begin
            repeat (tmo_eff) levels.push_back(1'b1);
        end else begin
            repeat (ready_delay) levels.push_back(1'b1);
            levels.push_back(1'b0);
            // Only the last tick of each low half matters; the rest is random.
            for (int p = 0; p < total; p++) begin
                for (int h = 0; h < 2 * half_n; h++) begin
                    if (h == 2 * half_n - 1 && p < lcasr_pkg::DATA_BITS) begin
                        levels.push_back(word[lcasr_pkg::DATA_BITS - 1 - p]);
                    end else begin
                        levels.push_back(1'($urandom_range(0, 1)));
                    end
                end
            end
        end
        abort_at = (noisy && $urandom_range(0, 9) == 0)
                   ? $urandom_range(0, levels.size() - 1) : -1;
        send_tick(lcasr_pkg::CMD_START, 1'($urandom_range(0, 1)));
        for (int i = 0; i < levels.size(); i++) begin
            if (i == abort_at) begin
                send_tick(lcasr_pkg::CMD_PDOWN, 1'($urandom_range(0, 1)));
                return;
            end
            send_tick(pick_filler(noisy), levels[i]);
        end
    endtask

    // Random commands, then power-down so the next read starts from a known phase.
    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 6);
        calm = 1'b0;
        repeat (n) begin
            send_tick(lcasr_pkg::cmd_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
        send_tick(lcasr_pkg::CMD_PDOWN, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1) == 1) begin
            send_tick(lcasr_pkg::CMD_PUP, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : stimulus
        lcasr_pkg::cfg_t random_settings[5];
        lcasr_pkg::cfg_t slow_settings;
        int   start_count;
        int   tmo_eff;
        int   pick;
        logic [23:0] word;

        random_settings = '{
            '{24'd1, 8'd1, 2'd3},
            '{24'd0, 8'd2, 2'd2},
            '{24'd3, 8'd0, 2'd0},
            '{24'hFFFFFF, 8'd1, 2'd1},
            '{24'd6, 8'd3, 2'd2}
        };
        slow_settings = '{24'd2, 8'd7, 2'd1};

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_we <= 1'b0;
        cfg_addr <= lcasr_pkg::REG_TIMEOUT;
        cfg_wdata <= '0;
        calm = 1'b0;
        items_sent = 0;
        cur_cfg = '{lcasr_pkg::TIMEOUT_RESET, lcasr_pkg::HALF_RESET, lcasr_pkg::EXTRA_RESET};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: idle ticks, ignored power-up, power-down and back, then reads
        // with the extreme words, the first one started from power-down.
        send_tick(lcasr_pkg::CMD_TICK, 1'b0);
        send_tick(lcasr_pkg::CMD_TICK, 1'b1);
        send_tick(lcasr_pkg::CMD_PUP, 1'b1);
        send_tick(lcasr_pkg::CMD_PDOWN, 1'b0);
        send_tick(lcasr_pkg::CMD_TICK, 1'b1);
        send_tick(lcasr_pkg::CMD_PUP, 1'b0);
        send_tick(lcasr_pkg::CMD_PDOWN, 1'b1);
        run_read(0, 24'hFFFFFF, 1'b0);
        run_read(3, 24'h000000, 1'b0);
        run_read(1, 24'h800000, 1'b0);
        run_read(2, 24'h7FFFFF, 1'b0);

        // Shortest timeout and most extra pulses: one timeout, one good read.
        apply_settings(random_settings[0]);
        run_read(1, 24'hA5C3F0, 1'b0);
        run_read(0, 24'h5A3C0F, 1'b0);

        // A long half period: a single read and a timeout.
        apply_settings(slow_settings);
        run_read(1, 24'($urandom), 1'b0);
        run_read(2, 24'($urandom), 1'b0);

        // Random reads, timeouts and command noise under each setting.
        foreach (random_settings[k]) begin
            apply_settings(random_settings[k]);
            tmo_eff = (cur_cfg.timeout_ticks == 24'd0) ? 1 : int'(cur_cfg.timeout_ticks);
            start_count = items_sent;
            while (items_sent - start_count < PHASE_BUDGET) begin
                pick = $urandom_range(0, 9);
                word = ($urandom_range(0, 7) == 0) ? {24{1'($urandom_range(0, 1))}}
                       : 24'($urandom);
                if (pick < 7) begin
                    run_read($urandom_range(0, (tmo_eff - 1 < 6) ? tmo_eff - 1 : 6), word, 1'b1);
                end else if (pick < 8 && tmo_eff <= 8) begin
                    run_read(tmo_eff, word, 1'b1);
                end else begin
                    noise_burst();
                end
            end
        end

        // Wait for the last results, then settle before the verdict.
        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("[load_cell_adc_serial_reader_top] OK");
        end else begin
            $display("[load_cell_adc_serial_reader_top] ERROR");
        end
        $finish;
    end

endmodule
